// ===== rtl/tstm_pkg.sv =====
// shared types, constants and helper functions of the slot table manager
`default_nettype none

package tstm_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CAP_W       = 11;
  localparam int LOG_W       = 4;
  localparam int RUN_W       = 4;
  localparam int TAG_W       = 32;
  localparam int SEC_W       = 32;
  localparam int TO_W        = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int FUNC_W      = 2;
  localparam int SLOT_W      = 12;
  localparam int STAT_W      = 2;
  localparam int RCNT_W      = RUN_W + 1;

  localparam logic [LOG_W-1:0] CAP_RESET_LOG2 = LOG_W'(9);
  localparam logic [TO_W-1:0]  TIMEOUT_RESET  = TO_W'(3600);

  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLAIM = 2'd2;

  localparam logic [STAT_W-1:0] STAT_MATCH     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_COLLISION = 2'd2;

  typedef enum logic [0:0] {
    REG_SLOT_CAPACITY = 1'b0,
    REG_IDLE_TIMEOUT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CUR, S_SCAN, S_CL_RD, S_CL_WAIT, S_CL_WR,
    S_SW_RD, S_SW_EV, S_FR_RD, S_FR_EV, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PASS_OWNER, PASS_MUL4, PASS_MUL2, PASS_ODD
  } pass_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  tag_id;
    logic [SLOT_W-1:0] current_slot;
    logic [SEC_W-1:0]  now_seconds;
    logic              preempt;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] check_status;
    logic              misplaced;
    logic              slot_valid;
    logic [IDX_W-1:0]  slot_index;
    logic [RUN_W-1:0]  run_extra;
    logic [CAP_W-1:0]  freed_count;
  } out_item_t;

  typedef struct packed {
    logic             used;
    logic [RUN_W-1:0] run_extra;
    logic [TAG_W-1:0] owner;
    logic [SEC_W-1:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  // log2 of the largest power of two not above v, clamped to 2 .. IDX_W (capacity 4 .. TABLE_DEPTH)
  function automatic logic [LOG_W-1:0] cap_log2(input logic [CAP_W-1:0] v);
    logic [LOG_W-1:0] res;
    res = LOG_W'(2);
    for (int b = 2; b < CAP_W; b++) begin
      if (v[b] && b <= IDX_W) res = LOG_W'(b);
    end
    if (v >= CAP_W'(TABLE_DEPTH)) res = LOG_W'(IDX_W);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tstm_if.sv =====
// valid/ready channels for input items and result items
`default_nettype none

interface tstm_in_if;
  import tstm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tstm_out_if;
  import tstm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/tstm_entry_ram.sv =====
// slot entry memory, one write and one registered read per cycle
`default_nettype none

module tstm_entry_ram
  import tstm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire ram_wr_t          wr_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tdma_slot_table_manager_core.sv =====
// slot table manager top level: control sequencer around the entry memory
// preempted checks and unknown operations go straight to completion; a check ends on a
//   match of the current slot, else runs the owner search and, while empty slots remain,
//   the three allocation passes; a claim grows a run over free slots; a sweep visits run
//   heads and frees the slots of expired runs and the tails of trimmed runs
// throughput: one item at a time, set by the single read port of the entry memory
// reset and any capacity write start a clearing pass over all 1024 entries, no item taken
`default_nettype none

module tdma_slot_table_manager_core
  import tstm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  tstm_in_if.sink                    in_i,
  tstm_out_if.source                 out_o
);

  state_e              state_q, state_d;
  pass_e               pass_q, pass_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [LOG_W-1:0]    log2_q, log2_d;
  logic [TO_W-1:0]     timeout_q, timeout_d;
  logic [CAP_W-1:0]    empty_q, empty_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  in_item_t            item_q, item_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [CAP_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic [2:0]          step_q, step_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    rdaddr_q;
  logic [RUN_W-1:0]    k_q, k_d;
  logic [CAP_W-1:0]    climit_q, climit_d;
  logic [CAP_W-1:0]    i_q, i_d;
  logic [RCNT_W-1:0]   j_q, j_d;
  logic [RCNT_W-1:0]   rcnt_q, rcnt_d;
  logic [CAP_W-1:0]    freed_q, freed_d;
  out_item_t           res_q, res_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  ram_wr_t             wr;
  logic [IDX_W-1:0]    raddr;
  entry_t              rdata;

  // scan and position helpers
  logic [IDX_W-1:0]    mask;
  logic [CAP_W-1:0]    scan_lim;
  logic                hit;
  logic [IDX_W-1:0]    b4, b2, cur_in;
  logic [CAP_W-1:0]    cl_pos;
  logic [CAP_W:0]      fr_pos;
  logic [SEC_W-1:0]    elapsed;
  logic [CAP_W+3:0]    empty_x10;
  logic [RCNT_W-1:0]   run_cnt;

  tstm_entry_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mask      = cap_q[IDX_W-1:0] - IDX_W'(1);
  assign cur_in    = in_i.payload.current_slot[SLOT_W-1:2] & mask;
  // round up the current slot to a multiple of 4 and of 2, wrapping mod table
  assign b4        = {cur_q[IDX_W-1:2], 2'b00} + ((|cur_q[1:0]) ? IDX_W'(4) : IDX_W'(0));
  assign b2        = {cur_q[IDX_W-1:1], 1'b0} + (cur_q[0] ? IDX_W'(2) : IDX_W'(0));
  assign cl_pos    = CAP_W'(cur_q) + CAP_W'(k_q) + CAP_W'(1);
  assign fr_pos    = (CAP_W+1)'(i_q) + (CAP_W+1)'(j_q);
  assign elapsed   = item_q.now_seconds - rdata.last_seen;
  // scarce when empty < cap/10, i.e. 10*(empty+1) <= cap
  assign empty_x10 = ((CAP_W+4)'(empty_q) + (CAP_W+4)'(1)) * (CAP_W+4)'(10);
  assign run_cnt   = RCNT_W'(rdata.run_extra) + RCNT_W'(1);

  always_comb begin
    case (pass_q)
      PASS_OWNER: scan_lim = cap_q;
      PASS_ODD:   scan_lim = cap_q >> 1;
      default:    scan_lim = cap_q >> 2;
    endcase
  end

  // owner pass looks for the tag, allocation passes for a free slot
  assign hit = pend_q && ((pass_q == PASS_OWNER) ?
               (rdata.used && rdata.owner == item_q.tag_id) : !rdata.used);

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    cap_d       = cap_q;
    log2_d      = log2_q;
    timeout_d   = timeout_q;
    empty_d     = empty_q;
    clr_d       = clr_q;
    item_d      = item_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    step_d      = step_q;
    pend_d      = 1'b0;
    k_d         = k_q;
    climit_d    = climit_q;
    i_d         = i_q;
    j_d         = j_q;
    rcnt_d      = rcnt_q;
    freed_d     = freed_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr          = '0;
    raddr       = '0;

    if (out_o.valid && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      // write every entry as free
      S_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = clr_q;
        clr_d   = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_i.valid) begin
          item_d = in_i.payload;
          cur_d  = cur_in;
          res_d  = '0;
          raddr  = cur_in;
          if ((in_i.payload.func == FUNC_CHECK && !in_i.payload.preempt) ||
              in_i.payload.func == FUNC_CLAIM) begin
            state_d = S_CUR;
          end else if (in_i.payload.func == FUNC_SWEEP) begin
            i_d     = '0;
            freed_d = '0;
            state_d = S_SW_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // entry of the current slot is on the read port
      S_CUR: begin
        if (item_q.func == FUNC_CLAIM) begin
          if (rdata.used) begin
            state_d = S_DONE;
          end else begin
            climit_d = empty_q >> (log2_q - LOG_W'(2));
            k_d      = '0;
            state_d  = S_CL_RD;
          end
        end else if (rdata.used && rdata.owner == item_q.tag_id) begin
          wr.we                = 1'b1;
          wr.addr              = cur_q;
          wr.data              = rdata;
          wr.data.last_seen    = item_q.now_seconds;
          res_d.check_status   = STAT_MATCH;
          state_d              = S_DONE;
        end else begin
          res_d.check_status = rdata.used ? STAT_COLLISION : STAT_EMPTY;
          pass_d  = PASS_OWNER;
          cnt_d   = '0;
          addr_d  = '0;
          step_d  = 3'd1;
          state_d = S_SCAN;
        end
      end

      // pipelined scan: one read issued per cycle while a pass runs, its data checked in the cycle after
      S_SCAN: begin
        if (hit) begin
          res_d.slot_valid = 1'b1;
          res_d.slot_index = rdaddr_q;
          if (pass_q == PASS_OWNER) begin
            res_d.misplaced = 1'b1;
            res_d.run_extra = rdata.run_extra;
          end else begin
            wr.we                = 1'b1;
            wr.addr              = rdaddr_q;
            wr.data.used         = 1'b1;
            wr.data.run_extra    = '0;
            wr.data.owner        = item_q.tag_id;
            wr.data.last_seen    = item_q.now_seconds;
            if (empty_q != '0) empty_d = empty_q - CAP_W'(1);
          end
          state_d = S_DONE;
        end else if (cnt_q < scan_lim) begin
          raddr  = addr_q & mask;
          pend_d = 1'b1;
          cnt_d  = cnt_q + CAP_W'(1);
          addr_d = addr_q + IDX_W'(step_q);
        end else begin
          cnt_d = '0;
          case (pass_q)
            PASS_OWNER: begin
              if (empty_q != '0) begin
                pass_d = PASS_MUL4;
                addr_d = b4;
                step_d = 3'd4;
              end else begin
                state_d = S_DONE;
              end
            end
            PASS_MUL4: begin
              pass_d = PASS_MUL2;
              addr_d = b4 + IDX_W'(2);
              step_d = 3'd4;
            end
            PASS_MUL2: begin
              pass_d = PASS_ODD;
              addr_d = b2 + IDX_W'(1);
              step_d = 3'd2;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // grow the claimed run over free slots up to the limit and table end
      S_CL_RD: begin
        if (CAP_W'(k_q) < climit_q && cl_pos < cap_q) begin
          raddr   = cl_pos[IDX_W-1:0];
          state_d = S_CL_WAIT;
        end else begin
          j_d     = '0;
          state_d = S_CL_WR;
        end
      end

      S_CL_WAIT: begin
        if (!rdata.used) begin
          k_d     = k_q + RUN_W'(1);
          state_d = S_CL_RD;
        end else begin
          j_d     = '0;
          state_d = S_CL_WR;
        end
      end

      S_CL_WR: begin
        wr.we             = 1'b1;
        wr.addr           = cur_q + IDX_W'(j_q);
        wr.data.used      = 1'b1;
        wr.data.run_extra = k_q;
        wr.data.owner     = item_q.tag_id;
        wr.data.last_seen = item_q.now_seconds;
        if (empty_q != '0) empty_d = empty_q - CAP_W'(1);
        j_d = j_q + RCNT_W'(1);
        if (j_q == RCNT_W'(k_q)) begin
          res_d.slot_valid = 1'b1;
          res_d.slot_index = cur_q;
          res_d.run_extra  = k_q;
          state_d          = S_DONE;
        end
      end

      // sweep walks run heads
      S_SW_RD: begin
        if (i_q < cap_q) begin
          raddr   = i_q[IDX_W-1:0];
          state_d = S_SW_EV;
        end else begin
          res_d.freed_count = freed_q;
          state_d           = S_DONE;
        end
      end

      S_SW_EV: begin
        rcnt_d = run_cnt;
        if (!rdata.used) begin
          i_d     = i_q + CAP_W'(1);
          state_d = S_SW_RD;
        end else if (elapsed > SEC_W'(timeout_q)) begin
          j_d     = '0;
          state_d = S_FR_RD;
        end else if (run_cnt > RCNT_W'(1) && empty_x10 <= (CAP_W+4)'(cap_q)) begin
          // trim: keep the head as a single slot, free the tail
          wr.we             = 1'b1;
          wr.addr           = i_q[IDX_W-1:0];
          wr.data           = rdata;
          wr.data.run_extra = '0;
          j_d               = RCNT_W'(1);
          state_d           = S_FR_RD;
        end else begin
          i_d     = i_q + CAP_W'(run_cnt);
          state_d = S_SW_RD;
        end
      end

      S_FR_RD: begin
        if (j_q < rcnt_q && fr_pos < (CAP_W+1)'(cap_q)) begin
          raddr   = fr_pos[IDX_W-1:0];
          state_d = S_FR_EV;
        end else begin
          i_d     = i_q + CAP_W'(rcnt_q);
          state_d = S_SW_RD;
        end
      end

      S_FR_EV: begin
        if (rdata.used) begin
          wr.we        = 1'b1;
          wr.addr      = fr_pos[IDX_W-1:0];
          wr.data      = rdata;
          wr.data.used = 1'b0;
          empty_d      = empty_q + CAP_W'(1);
          freed_d      = freed_q + CAP_W'(1);
        end
        j_d     = j_q + RCNT_W'(1);
        state_d = S_FR_RD;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // configuration writes must arrive only while idle or clearing; the block does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SLOT_CAPACITY: begin
          log2_d  = cap_log2(cfg_data_i[CAP_W-1:0]);
          cap_d   = CAP_W'(1) << cap_log2(cfg_data_i[CAP_W-1:0]);
          empty_d = CAP_W'(1) << cap_log2(cfg_data_i[CAP_W-1:0]);
          clr_d   = '0;
          state_d = S_CLEAR;
        end
        REG_IDLE_TIMEOUT: timeout_d = cfg_data_i[TO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      log2_q      <= CAP_RESET_LOG2;
      cap_q       <= CAP_W'(1) << CAP_RESET_LOG2;
      empty_q     <= CAP_W'(1) << CAP_RESET_LOG2;
      timeout_q   <= TIMEOUT_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pass_q      <= PASS_OWNER;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      log2_q      <= log2_d;
      cap_q       <= cap_d;
      empty_q     <= empty_d;
      timeout_q   <= timeout_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    addr_q   <= addr_d;
    step_q   <= step_d;
    rdaddr_q <= raddr;
    k_q      <= k_d;
    climit_q <= climit_d;
    i_q      <= i_d;
    j_q      <= j_d;
    rcnt_q   <= rcnt_d;
    freed_q  <= freed_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // empty count never exceeds the capacity
  a_empty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q <= cap_q) else $error("empty count above capacity");

  // a capacity write always starts a clearing pass
  a_cap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == REG_SLOT_CAPACITY |=> state_q == S_CLEAR)
    else $error("capacity write without clearing pass");

  // a new result comes only from the completion state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside completion");

  // pending scan data only follows a scan cycle
  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q) == S_SCAN) else $error("stray pending read");

endmodule

`default_nettype wire

// ===== bench/tdma_slot_table_manager_core_tb.sv =====
// testbench for the slot table manager: directed and randomized items checked against a behavioral model
`timescale 1ns / 1ps

module tdma_slot_table_manager_core_tb;
  import tstm_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tstm_in_if  in_ch ();
  tstm_out_if out_ch ();

  tdma_slot_table_manager_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  // model copy of the slot table
  logic             mdl_used [TABLE_DEPTH];
  logic [RUN_W-1:0] mdl_run  [TABLE_DEPTH];
  logic [TAG_W-1:0] mdl_owner[TABLE_DEPTH];
  logic [SEC_W-1:0] mdl_seen [TABLE_DEPTH];
  int unsigned      mdl_empty;
  int unsigned      mdl_cap;
  int unsigned      mdl_timeout;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        mismatches;

  // recent tags, so arrivals revisit owners
  logic [TAG_W-1:0] tag_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_capacity(input logic [CAP_W-1:0] v);
    int unsigned p;
    p = 4;
    while (p * 2 <= v && p * 2 <= TABLE_DEPTH) p = p * 2;
    return p;
  endfunction

  function automatic void wipe_table();
    for (int k = 0; k < TABLE_DEPTH; k++) mdl_used[k] = 1'b0;
    mdl_empty = mdl_cap;
  endfunction

  function automatic void occupy(input int unsigned s, input logic [TAG_W-1:0] tag,
                                 input logic [SEC_W-1:0] now, input int unsigned extra);
    mdl_used[s]  = 1'b1;
    mdl_run[s]   = RUN_W'(extra);
    mdl_owner[s] = tag;
    mdl_seen[s]  = now;
    if (mdl_empty > 0) mdl_empty--;
  endfunction

  function automatic bit find_free(input int unsigned base, input int unsigned off,
                                   input int unsigned step, output int unsigned found);
    int unsigned s;
    for (int unsigned k = 0; k < mdl_cap; k += step) begin
      s = (base + k + off) & (mdl_cap - 1);
      if (!mdl_used[s]) begin
        found = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // computes the result of one item and updates the model table
  function automatic out_item_t slot_table_predict(input in_item_t it);
    out_item_t   r;
    int unsigned cur, s, b4, b2, lim, k, cnt;
    bit          matched, ok;
    r   = '0;
    cur = (int'(it.current_slot) >> 2) & (mdl_cap - 1);
    if (it.func == FUNC_CHECK && !it.preempt) begin
      matched = 1'b0;
      if (mdl_used[cur]) begin
        if (mdl_owner[cur] == it.tag_id) begin
          mdl_seen[cur] = it.now_seconds;
          matched = 1'b1;
        end else r.check_status = STAT_COLLISION;
      end else r.check_status = STAT_EMPTY;
      if (!matched) begin
        for (int unsigned i = 0; i < mdl_cap; i++) begin
          if (mdl_used[i] && mdl_owner[i] == it.tag_id) begin
            r.misplaced  = 1'b1;
            r.slot_valid = 1'b1;
            r.slot_index = IDX_W'(i);
            r.run_extra  = mdl_run[i];
            break;
          end
        end
        if (!r.misplaced && mdl_empty != 0) begin
          b4 = (cur & ~3) + ((cur & 3) != 0 ? 4 : 0);
          b2 = (cur & ~1) + ((cur & 1) != 0 ? 2 : 0);
          ok = find_free(b4, 0, 4, s);
          if (!ok) ok = find_free(b4, 2, 4, s);
          if (!ok) ok = find_free(b2, 1, 2, s);
          if (ok) begin
            occupy(s, it.tag_id, it.now_seconds, 0);
            r.slot_valid = 1'b1;
            r.slot_index = IDX_W'(s);
          end
        end
      end
    end else if (it.func == FUNC_CLAIM) begin
      if (!mdl_used[cur]) begin
        lim = mdl_empty / (mdl_cap >> 2);
        k   = 0;
        while (k < lim && cur + k + 1 < mdl_cap && !mdl_used[cur + k + 1]) k++;
        for (int unsigned i = 0; i <= k; i++) occupy(cur + i, it.tag_id, it.now_seconds, k);
        r.slot_valid = 1'b1;
        r.slot_index = IDX_W'(cur);
        r.run_extra  = RUN_W'(k);
      end
    end else if (it.func == FUNC_SWEEP) begin
      s = 0;
      while (s < mdl_cap) begin
        if (!mdl_used[s]) begin
          s++;
          continue;
        end
        cnt = int'(mdl_run[s]) + 1;
        if (32'(it.now_seconds - mdl_seen[s]) > mdl_timeout) begin
          for (int unsigned j = 0; j < cnt && s + j < mdl_cap; j++)
            if (mdl_used[s + j]) begin
              mdl_used[s + j] = 1'b0;
              mdl_empty++;
              r.freed_count++;
            end
        end else if (cnt > 1 && mdl_empty < mdl_cap / 10) begin
          mdl_run[s] = '0;
          for (int unsigned j = 1; j < cnt && s + j < mdl_cap; j++)
            if (mdl_used[s + j]) begin
              mdl_used[s + j] = 1'b0;
              mdl_empty++;
              r.freed_count++;
            end
        end
        s += cnt;
      end
    end
    return r;
  endfunction

  // driver: feeds pending items with a random gap before each
  int  send_gap;
  int  send_draw;
  bit  send_gap_drawn;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid    <= 1'b0;
      in_ch.payload  <= '0;
      send_gap       <= 0;
      send_gap_drawn <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(slot_table_predict(in_ch.payload));
        void'(pending_items.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the item
      end else if (pending_items.size() > 0) begin
        if (!send_gap_drawn) begin
          send_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
          if (send_draw == 0) begin
            in_ch.valid   <= 1'b1;
            in_ch.payload <= pending_items[0];
          end else begin
            send_gap       <= send_draw - 1;
            send_gap_drawn <= 1'b1;
            in_ch.valid    <= 1'b0;
          end
        end else if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid    <= 1'b1;
          in_ch.payload  <= pending_items[0];
          send_gap_drawn <= 1'b0;
        end
      end else in_ch.valid <= 1'b0;
    end
  end

  // monitor: random stalls on the result side, checks each accepted result
  int recv_gap;
  int recv_draw;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.payload);
        end else begin
          if (out_ch.payload !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_results[0], out_ch.payload);
          end
          void'(expected_results.pop_front());
        end
        recv_draw    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        recv_gap     <= recv_draw;
        out_ch.ready <= (recv_draw == 0);
      end else if (recv_gap > 1) begin
        recv_gap     <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        recv_gap     <= 0;
        out_ch.ready <= 1'b1;
      end
    end
  end

  // register write, meant for use only while idle; the task itself does not enforce it
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_SLOT_CAPACITY) begin
      mdl_cap = eff_capacity(val[CAP_W-1:0]);
      wipe_table();
    end else mdl_timeout = val;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (4500) @(posedge clk_i);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    logic [TAG_W-1:0] t;
    if (tag_pool.size() != 0 && $urandom_range(0, 2) != 0)
      return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    t = $urandom();
    tag_pool.push_back(t);
    if (tag_pool.size() > 24) void'(tag_pool.pop_front());
    return t;
  endfunction

  function automatic in_item_t make_item(input logic [FUNC_W-1:0] f, input logic [SEC_W-1:0] now);
    in_item_t it;
    it.func         = f;
    it.tag_id       = pick_tag();
    it.current_slot = SLOT_W'($urandom_range(0, 4095));
    it.now_seconds  = now;
    it.preempt      = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  task automatic run_phase(input int n, input logic [SEC_W-1:0] start_sec);
    in_item_t         it;
    logic [SEC_W-1:0] now;
    int               pick;
    now = start_sec;
    for (int k = 0; k < n; k++) begin
      now  = now + $urandom_range(0, 400);
      pick = $urandom_range(0, 19);
      if (pick < 12)      it = make_item(FUNC_CHECK, now);
      else if (pick < 16) it = make_item(FUNC_CLAIM, now);
      else if (pick < 19) it = make_item(FUNC_SWEEP, now);
      else                it = make_item(2'd3, now);
      pending_items.push_back(it);
    end
    wait_idle();
  endtask

  initial begin
    in_item_t it;
    mismatches   = 0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_SLOT_CAPACITY;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    mdl_cap      = 512;
    mdl_timeout  = 3600;
    wipe_table();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: smallest table, extreme fields, every operation
    write_reg(REG_SLOT_CAPACITY, 16'd4);
    write_reg(REG_IDLE_TIMEOUT, 16'd0);
    it = '{func: FUNC_CHECK, tag_id: 32'hFFFF_FFFF, current_slot: 12'hFFF,
           now_seconds: 32'hFFFF_FFFF, preempt: 1'b0};
    pending_items.push_back(it);
    pending_items.push_back(it);                        // misplaced
    it.preempt = 1'b1;
    pending_items.push_back(it);                        // preempt
    it = '{func: FUNC_CHECK, tag_id: 32'h0, current_slot: 12'h000,
           now_seconds: 32'h0, preempt: 1'b0};
    pending_items.push_back(it);                        // collision or misplaced
    it.current_slot = 12'h00C;
    pending_items.push_back(it);
    for (int k = 1; k < 5; k++) begin
      it.tag_id = k;
      pending_items.push_back(it);                      // fills up, then table full
    end
    it.func = FUNC_CLAIM;
    pending_items.push_back(it);                        // claim on used slot
    it.func = FUNC_SWEEP;
    it.now_seconds = 32'h0000_0002;
    pending_items.push_back(it);                        // wrapped elapsed, frees all
    it.func = FUNC_CLAIM;
    it.tag_id = 32'hA5A5_5A5A;
    pending_items.push_back(it);                        // claim, run stops at the table end
    it.func = 2'd3;
    pending_items.push_back(it);                        // unknown operation
    wait_idle();

    // capacity out of range, claimed runs and a sweep that keeps them
    write_reg(REG_SLOT_CAPACITY, 16'h07FF);
    write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
    for (int k = 0; k < 8; k++) begin
      it = '{func: FUNC_CLAIM, tag_id: $urandom(), current_slot: 12'(k * 16),
             now_seconds: 32'd100, preempt: 1'b0};
      pending_items.push_back(it);
    end
    it.func = FUNC_SWEEP;
    pending_items.push_back(it);
    wait_idle();

    write_reg(REG_SLOT_CAPACITY, 16'd16);
    write_reg(REG_IDLE_TIMEOUT, 16'd600);
    run_phase(140, $urandom());
    write_reg(REG_SLOT_CAPACITY, 16'd5);
    write_reg(REG_IDLE_TIMEOUT, 16'd3600);
    run_phase(120, 32'hFFFF_0000);
    write_reg(REG_SLOT_CAPACITY, 16'd64);
    write_reg(REG_IDLE_TIMEOUT, 16'd1500);
    run_phase(180, $urandom());
    write_reg(REG_SLOT_CAPACITY, 16'd1024);
    write_reg(REG_IDLE_TIMEOUT, 16'd2000);
    run_phase(60, $urandom());

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #150ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tstm_pkg.sv
rtl/tstm_if.sv
rtl/tstm_entry_ram.sv
rtl/tdma_slot_table_manager_core.sv
bench/tdma_slot_table_manager_core_tb.sv
